### rtl/core/dcs_pkg.sv
// Shared constants, codes and helpers of the copy selector.
package dcs_pkg;

	localparam int unsigned NUM_COPIES = 4;
	localparam int unsigned NUM_LEVELS = 4;

	localparam int unsigned FREQ_W   = 10;
	localparam int unsigned LEVEL_W  = 2;
	localparam int unsigned COPY_W   = 2;
	localparam int unsigned INDEX_W  = 4;
	localparam int unsigned ACTION_W = 2;
	localparam int unsigned LEVELS_W = NUM_LEVELS * FREQ_W;
	localparam int unsigned CFG_IDX_W = 2;

	localparam int unsigned FREQ_STEP = 200;

	localparam logic [LEVELS_W-1:0] LEVELS_RST = LEVELS_W'(64'd537185689700);
	localparam logic [FREQ_W-1:0]   CAP_RST    = FREQ_W'(900);

	typedef logic [FREQ_W-1:0] freq_t;
	typedef logic [COPY_W-1:0] copy_t;

	typedef enum logic [ACTION_W-1:0] {
		ACT_IGNORE  = 2'd0,
		ACT_HIT     = 2'd1,
		ACT_CP_NEAR = 2'd2,
		ACT_AP_REPL = 2'd3
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_AP_LEVELS    = 2'd0,
		REG_CP_LEVELS    = 2'd1,
		REG_FREQ_CAP     = 2'd2,
		REG_COMBINE_MODE = 2'd3
	} cfg_reg_t;

	// Frequency of one level; levels past the table saturate to the last one.
	function automatic freq_t level_freq(input logic [LEVELS_W-1:0] lvls,
	                                     input logic [LEVEL_W-1:0] lv);
		logic [LEVEL_W-1:0] l;
		l = lv;
		if (l > LEVEL_W'(NUM_LEVELS - 1)) begin
			l = LEVEL_W'(NUM_LEVELS - 1);
		end
		return lvls[l*FREQ_W +: FREQ_W];
	endfunction

	function automatic freq_t copy_reset(input int unsigned i);
		return FREQ_W'(FREQ_STEP * (i + 1));
	endfunction

endpackage

### rtl/core/dvfs_copy_select.sv
// Copy selector top level: index forming, frequency lookup, copy choice and state.
//
// Each vote beat on the slave side (tuser = voter, 1 AP / 0 CP; tdata = level)
// yields exactly one result beat on the master side. The vote is held in an
// input register. The lookup, the compare over the four timing copies and the
// copy update work on the registered vote, and the result is then held in an
// output register. One vote is taken every cycle when the master side keeps
// up; the rate is set by the update of the current copy, index and copy table,
// which the next vote reads. Configuration writes are always ready and take
// effect at once; write them only while no vote is in flight.
module dvfs_copy_select (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [7:0]                          s_tdata,   // level[1:0], zero fill
	input  logic                                s_tuser,   // source
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [15:0]                         m_tdata,   // copy_selected[1:0], op_index[5:2], target_freq[15:6]
	output logic [dcs_pkg::ACTION_W-1:0]        m_tuser,   // action
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [dcs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [dcs_pkg::LEVELS_W-1:0]        cfg_data
);

	// configuration
	logic [dcs_pkg::LEVELS_W-1:0] ap_levels_q;
	logic [dcs_pkg::LEVELS_W-1:0] cp_levels_q;
	dcs_pkg::freq_t               freq_cap_q;
	logic                         combine_mode_q;

	// policy state
	dcs_pkg::freq_t                 copy_freq_q [dcs_pkg::NUM_COPIES];
	dcs_pkg::copy_t                 active_copy_q;
	logic [dcs_pkg::INDEX_W-1:0]    active_index_q;

	// input stage
	logic                           vld_s1;
	logic                           src_s1;
	logic [dcs_pkg::LEVEL_W-1:0]    level_s1;

	// output stage
	logic                           out_vld_q;
	dcs_pkg::action_t               out_action_q;
	dcs_pkg::copy_t                 out_copy_q;
	logic [dcs_pkg::INDEX_W-1:0]    out_index_q;
	dcs_pkg::freq_t                 out_freq_q;

	logic                           advance;

	logic [dcs_pkg::INDEX_W-1:0]    idx;
	dcs_pkg::freq_t                 ap_f;
	dcs_pkg::freq_t                 cp_f;
	logic [dcs_pkg::FREQ_W:0]       sum_f;
	dcs_pkg::freq_t                 tgt_f;

	logic                           hit;
	dcs_pkg::copy_t                 hit_sel;

	logic                           cp_found;
	dcs_pkg::freq_t                 cp_best;
	dcs_pkg::copy_t                 cp_near;
	dcs_pkg::freq_t                 hi_val;
	dcs_pkg::copy_t                 hi_sel;
	dcs_pkg::copy_t                 cp_sel;

	logic                           up_found;
	dcs_pkg::freq_t                 up_best;
	dcs_pkg::copy_t                 up_sel;
	logic                           dn_found;
	dcs_pkg::freq_t                 dn_best;
	dcs_pkg::copy_t                 dn_sel;
	dcs_pkg::copy_t                 victim;
	dcs_pkg::copy_t                 ap_sel;

	dcs_pkg::action_t               action;
	dcs_pkg::copy_t                 res_copy;

	assign advance   = vld_s1 && (!out_vld_q || m_tready);
	assign s_tready  = !vld_s1 || advance;
	assign cfg_ready = 1'b1;

	assign m_tvalid = out_vld_q;
	assign m_tuser  = out_action_q;
	assign m_tdata  = {out_freq_q, out_index_q, out_copy_q};

	// index and target frequency
	assign idx  = src_s1 ? {level_s1, active_index_q[1:0]} : {active_index_q[3:2], level_s1};
	assign ap_f = dcs_pkg::level_freq(ap_levels_q, idx[3:2]);
	assign cp_f = dcs_pkg::level_freq(cp_levels_q, idx[1:0]);
	assign sum_f = {1'b0, ap_f} + {1'b0, cp_f};

	always_comb begin
		if (combine_mode_q) begin
			tgt_f = (ap_f > cp_f) ? ap_f : cp_f;
		end else if (sum_f > {1'b0, freq_cap_q}) begin
			tgt_f = freq_cap_q;
		end else begin
			tgt_f = sum_f[dcs_pkg::FREQ_W-1:0];
		end
	end

	// lowest copy holding the target exactly
	always_comb begin
		hit     = 1'b0;
		hit_sel = '0;
		for (int i = dcs_pkg::NUM_COPIES - 1; i >= 0; i--) begin
			if (copy_freq_q[i] == tgt_f) begin
				hit     = 1'b1;
				hit_sel = dcs_pkg::COPY_W'(i);
			end
		end
	end

	// CP miss: closest at or above, else highest
	always_comb begin
		cp_found = 1'b0;
		cp_best  = '0;
		cp_near  = '0;
		hi_val   = '0;
		hi_sel   = '0;
		for (int i = 0; i < dcs_pkg::NUM_COPIES; i++) begin
			if (copy_freq_q[i] >= tgt_f &&
			    (!cp_found || (copy_freq_q[i] - tgt_f) < cp_best)) begin
				cp_found = 1'b1;
				cp_best  = copy_freq_q[i] - tgt_f;
				cp_near  = dcs_pkg::COPY_W'(i);
			end
			if (copy_freq_q[i] > hi_val) begin
				hi_val = copy_freq_q[i];
				hi_sel = dcs_pkg::COPY_W'(i);
			end
		end
		cp_sel = cp_found ? cp_near : hi_sel;
	end

	// AP miss: closest strictly above, else closest strictly below
	always_comb begin
		up_found = 1'b0;
		up_best  = '0;
		up_sel   = '0;
		dn_found = 1'b0;
		dn_best  = '0;
		dn_sel   = '0;
		for (int i = 0; i < dcs_pkg::NUM_COPIES; i++) begin
			if (copy_freq_q[i] > tgt_f &&
			    (!up_found || (copy_freq_q[i] - tgt_f) < up_best)) begin
				up_found = 1'b1;
				up_best  = copy_freq_q[i] - tgt_f;
				up_sel   = dcs_pkg::COPY_W'(i);
			end
			if (copy_freq_q[i] < tgt_f &&
			    (!dn_found || (tgt_f - copy_freq_q[i]) < dn_best)) begin
				dn_found = 1'b1;
				dn_best  = tgt_f - copy_freq_q[i];
				dn_sel   = dcs_pkg::COPY_W'(i);
			end
		end
		victim = up_found ? up_sel : dn_sel;
		// move off the current copy: next one up, or one below for the last copy
		if (victim == active_copy_q) begin
			if (victim != dcs_pkg::COPY_W'(dcs_pkg::NUM_COPIES - 1)) begin
				ap_sel = victim + dcs_pkg::COPY_W'(1);
			end else begin
				ap_sel = dcs_pkg::COPY_W'(dcs_pkg::NUM_COPIES - 2);
			end
		end else begin
			ap_sel = victim;
		end
	end

	always_comb begin
		priority if (hit && hit_sel == active_copy_q) begin
			action   = dcs_pkg::ACT_IGNORE;
			res_copy = active_copy_q;
		end else if (hit) begin
			action   = dcs_pkg::ACT_HIT;
			res_copy = hit_sel;
		end else if (!src_s1) begin
			action   = dcs_pkg::ACT_CP_NEAR;
			res_copy = cp_sel;
		end else begin
			action   = dcs_pkg::ACT_AP_REPL;
			res_copy = ap_sel;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ap_levels_q    <= dcs_pkg::LEVELS_RST;
			cp_levels_q    <= dcs_pkg::LEVELS_RST;
			freq_cap_q     <= dcs_pkg::CAP_RST;
			combine_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (dcs_pkg::cfg_reg_t'(cfg_index))
				dcs_pkg::REG_AP_LEVELS:    ap_levels_q    <= cfg_data;
				dcs_pkg::REG_CP_LEVELS:    cp_levels_q    <= cfg_data;
				dcs_pkg::REG_FREQ_CAP:     freq_cap_q     <= cfg_data[dcs_pkg::FREQ_W-1:0];
				dcs_pkg::REG_COMBINE_MODE: combine_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			src_s1   <= s_tuser;
			level_s1 <= s_tdata[dcs_pkg::LEVEL_W-1:0];
		end
	end

	// policy state: commit on advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < dcs_pkg::NUM_COPIES; i++) begin
				copy_freq_q[i] <= dcs_pkg::copy_reset(i);
			end
			active_copy_q  <= '0;
			active_index_q <= '0;
		end else if (advance && action != dcs_pkg::ACT_IGNORE) begin
			active_copy_q  <= res_copy;
			active_index_q <= idx;
			if (action == dcs_pkg::ACT_AP_REPL) begin
				copy_freq_q[res_copy] <= tgt_f;
			end
		end
	end

	// output stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_action_q <= action;
			out_copy_q   <= res_copy;
			out_index_q  <= idx;
			out_freq_q   <= tgt_f;
		end
	end

endmodule

### sim/dcs_vote_checker.sv
// Checker of the copy selector: tracks its copy table, predicts every vote's result and compares.
module dcs_vote_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // level[1:0], zero fill
	input  logic                          s_tuser,   // source
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [15:0]                   m_tdata,   // copy_selected[1:0], op_index[5:2], target_freq[15:6]
	input  logic [dcs_pkg::ACTION_W-1:0]  m_tuser,   // action
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [dcs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dcs_pkg::LEVELS_W-1:0]  cfg_data,
	output int                            mismatches,
	output int                            awaited
);
	import dcs_pkg::*;

	typedef struct packed {
		action_t            act;
		copy_t              sel;
		logic [INDEX_W-1:0] idx;
		freq_t              freq;
	} selection_t;

	logic [LEVELS_W-1:0] ap_table;
	logic [LEVELS_W-1:0] cp_table;
	freq_t               cap;
	logic                max_mode;
	freq_t               copies [NUM_COPIES];
	copy_t               active_copy;
	logic [INDEX_W-1:0]  active_index;
	selection_t          awaited_selections [$];

	function automatic freq_t table_freq(input logic [LEVELS_W-1:0] tbl,
	                                     input logic [LEVEL_W-1:0] lv);
		int unsigned l;
		l = lv;
		if (l > NUM_LEVELS - 1) begin
			l = NUM_LEVELS - 1;
		end
		return tbl[l*FREQ_W +: FREQ_W];
	endfunction

	function automatic freq_t target_of(input logic [INDEX_W-1:0] idx);
		int unsigned a, c, s;
		a = table_freq(ap_table, idx[3:2]);
		c = table_freq(cp_table, idx[1:0]);
		if (max_mode) begin
			return freq_t'((a > c) ? a : c);
		end
		s = a + c;
		return freq_t'((s > cap) ? cap : s);
	endfunction

	// closest copy at or above f, else the highest one
	function automatic copy_t cp_nearest(input freq_t f);
		int unsigned k, hi, best, hival, v;
		bit found;
		k = 0;
		hi = 0;
		best = 0;
		hival = 0;
		found = 1'b0;
		for (int i = 0; i < NUM_COPIES; i++) begin
			v = copies[i];
			if (v >= f && (!found || v - f < best)) begin
				found = 1'b1;
				best = v - f;
				k = i;
			end
			if (v > hival) begin
				hival = v;
				hi = i;
			end
		end
		return copy_t'(found ? k : hi);
	endfunction

	// closest copy strictly above f, else closest strictly below
	function automatic copy_t ap_victim(input freq_t f);
		int unsigned k, best, v;
		bit found;
		k = 0;
		best = 0;
		found = 1'b0;
		for (int i = 0; i < NUM_COPIES; i++) begin
			v = copies[i];
			if (v > f && (!found || v - f < best)) begin
				found = 1'b1;
				best = v - f;
				k = i;
			end
		end
		if (!found) begin
			for (int i = 0; i < NUM_COPIES; i++) begin
				v = copies[i];
				if (v < f && (!found || f - v < best)) begin
					found = 1'b1;
					best = f - v;
					k = i;
				end
			end
		end
		return copy_t'(k);
	endfunction

	function automatic selection_t apply_vote(input logic ap_vote, input logic [LEVEL_W-1:0] lv);
		selection_t         r;
		logic [INDEX_W-1:0] idx;
		freq_t              f;
		int                 hit_at;
		copy_t              sel;
		idx = ap_vote ? {lv, active_index[1:0]} : {active_index[3:2], lv};
		f = target_of(idx);
		hit_at = -1;
		for (int i = NUM_COPIES - 1; i >= 0; i--) begin
			if (copies[i] == f) begin
				hit_at = i;
			end
		end
		if (hit_at >= 0) begin
			sel = copy_t'(hit_at);
			if (sel == active_copy) begin
				r.act = ACT_IGNORE;
			end else begin
				r.act = ACT_HIT;
				active_copy = sel;
				active_index = idx;
			end
		end else if (!ap_vote) begin
			r.act = ACT_CP_NEAR;
			active_copy = cp_nearest(f);
			active_index = idx;
		end else begin
			r.act = ACT_AP_REPL;
			sel = ap_victim(f);
			// never overwrite the copy in use: step up, or down from the last one
			if (sel == active_copy) begin
				sel = (sel != copy_t'(NUM_COPIES - 1)) ? copy_t'(sel + 1) : copy_t'(NUM_COPIES - 2);
			end
			copies[sel] = f;
			active_copy = sel;
			active_index = idx;
		end
		r.sel = active_copy;
		r.idx = idx;
		r.freq = f;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		selection_t want, got;
		if (!arst_n) begin
			ap_table = LEVELS_RST;
			cp_table = LEVELS_RST;
			cap = CAP_RST;
			max_mode = 1'b0;
			for (int i = 0; i < NUM_COPIES; i++) begin
				copies[i] = freq_t'(FREQ_STEP * (i + 1));
			end
			active_copy = '0;
			active_index = '0;
			awaited_selections.delete();
			mismatches = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_AP_LEVELS: begin
						ap_table = cfg_data;
					end
					REG_CP_LEVELS: begin
						cp_table = cfg_data;
					end
					REG_FREQ_CAP: begin
						cap = cfg_data[FREQ_W-1:0];
					end
					REG_COMBINE_MODE: begin
						max_mode = cfg_data[0];
					end
				endcase
			end
			if (s_tvalid && s_tready) begin
				awaited_selections.push_back(apply_vote(s_tuser, s_tdata[LEVEL_W-1:0]));
			end
			if (m_tvalid && m_tready) begin
				got.act = action_t'(m_tuser);
				got.sel = m_tdata[1:0];
				got.idx = m_tdata[5:2];
				got.freq = m_tdata[15:6];
				if (awaited_selections.size() == 0) begin
					$display("%0t: unexpected result beat, action %0d copy %0d index %0d freq %0d",
						$time, got.act, got.sel, got.idx, got.freq);
					mismatches++;
				end else begin
					want = awaited_selections.pop_front();
					if (got.act !== want.act) begin
						$display("%0t: action expected %0d got %0d", $time, want.act, got.act);
						mismatches++;
					end
					if (got.sel !== want.sel) begin
						$display("%0t: copy_selected expected %0d got %0d", $time, want.sel, got.sel);
						mismatches++;
					end
					if (got.idx !== want.idx) begin
						$display("%0t: op_index expected %0d got %0d", $time, want.idx, got.idx);
						mismatches++;
					end
					if (got.freq !== want.freq) begin
						$display("%0t: target_freq expected %0d got %0d", $time, want.freq, got.freq);
						mismatches++;
					end
				end
			end
		end
		awaited = awaited_selections.size();
	end

endmodule

### sim/dvfs_copy_select_tb.sv
// Testbench top of the copy selector: clock, reset, votes, register writes and verdict.
module dvfs_copy_select_tb;
	import dcs_pkg::*;

	localparam logic VOTER_AP = 1'b1;
	localparam logic VOTER_CP = 1'b0;
	localparam int   SETTINGS_PER_PHASE = 5;
	localparam int   VOTES_PER_SETTING  = 110;

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [7:0]           s_tdata   = '0;   // level[1:0], zero fill
	logic                 s_tuser   = 1'b0; // source
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [15:0]          m_tdata;          // copy_selected[1:0], op_index[5:2], target_freq[15:6]
	logic [ACTION_W-1:0]  m_tuser;          // action
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [LEVELS_W-1:0]  cfg_data  = '0;
	int                   mismatches;
	int                   awaited;
	int                   vote_gap_pct     = 0;
	int                   result_stall_pct = 0;

	dvfs_copy_select i_dut (.*);

	dcs_vote_checker i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("CHECKS FAILED");
		$finish;
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= result_stall_pct);
	end

	task automatic send_vote(input logic voter, input logic [LEVEL_W-1:0] lv);
		while ($urandom_range(99) < vote_gap_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= voter;
		s_tdata <= {{(8 - LEVEL_W){1'b0}}, lv};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// hold off until every vote has produced its beat, then let the pipeline settle
	task automatic drain();
		s_tvalid <= 1'b0;
		while (awaited != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t r, input logic [LEVELS_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= r;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic load_settings(input logic [LEVELS_W-1:0] ap, input logic [LEVELS_W-1:0] cp,
	                             input freq_t cap, input logic max_mode);
		write_reg(REG_AP_LEVELS, ap);
		write_reg(REG_CP_LEVELS, cp);
		write_reg(REG_FREQ_CAP, LEVELS_W'(cap));
		write_reg(REG_COMBINE_MODE, LEVELS_W'(max_mode));
		cfg_valid <= 1'b0;
	endtask

	// bias towards round values so targets often land on an existing copy
	function automatic freq_t rand_freq();
		case ($urandom_range(11))
			0: return '0;
			1: return freq_t'(999);
			2: return '1;
			3, 4, 5, 6: return freq_t'(100 * $urandom_range(9));
			default: return freq_t'($urandom_range(999));
		endcase
	endfunction

	function automatic freq_t rand_cap();
		case ($urandom_range(9))
			0: return '0;
			1: return freq_t'(999);
			2: return '1;
			3: return freq_t'(900);
			default: return freq_t'($urandom_range(999));
		endcase
	endfunction

	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		vote_gap_pct = 11;
		result_stall_pct = 49;

		// reset settings: every level of both voters, then a repeated CP vote that hits a copy and then the current copy
		send_vote(VOTER_CP, 0);
		send_vote(VOTER_CP, 1);
		send_vote(VOTER_CP, 2);
		send_vote(VOTER_CP, 3);
		send_vote(VOTER_AP, 1);
		send_vote(VOTER_AP, 2);
		send_vote(VOTER_AP, 3);
		send_vote(VOTER_AP, 0);
		send_vote(VOTER_CP, 0);
		send_vote(VOTER_CP, 0);

		// all-ones AP table, zero CP table, higher-of-two: AP rewrites a copy, then the same target is ignored
		drain();
		load_settings('1, '0, '1, 1'b1);
		send_vote(VOTER_AP, 3);
		send_vote(VOTER_AP, 3);
		send_vote(VOTER_CP, 2);

		// zero tables and zero cap: CP miss picks nearest above, AP rewrites with zero
		drain();
		load_settings('0, '0, '0, 1'b0);
		send_vote(VOTER_CP, 1);
		send_vote(VOTER_AP, 2);
		send_vote(VOTER_CP, 0);

		// sums above every copy, clamped to the cap
		drain();
		load_settings({10'd999, 10'd700, 10'd300, 10'd50}, {10'd999, 10'd500, 10'd100, 10'd0},
			freq_t'(999), 1'b0);
		send_vote(VOTER_CP, 3);
		send_vote(VOTER_AP, 3);
		send_vote(VOTER_AP, 0);
		send_vote(VOTER_CP, 0);
		send_vote(VOTER_AP, 1);

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					vote_gap_pct = 11;
					result_stall_pct = 49;
				end
				1: begin
					vote_gap_pct = 49;
					result_stall_pct = 11;
				end
				default: begin
					vote_gap_pct = 0;
					result_stall_pct = 0;
				end
			endcase
			for (int s = 0; s < SETTINGS_PER_PHASE; s++) begin
				drain();
				load_settings({rand_freq(), rand_freq(), rand_freq(), rand_freq()},
					{rand_freq(), rand_freq(), rand_freq(), rand_freq()},
					rand_cap(), 1'($urandom_range(1)));
				for (int n = 0; n < VOTES_PER_SETTING; n++) begin
					send_vote(1'($urandom_range(1)), LEVEL_W'($urandom_range(3)));
				end
			end
		end

		drain();
		repeat (8) @(negedge clk);
		if (mismatches == 0 && awaited == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/core/dcs_pkg.sv
rtl/core/dvfs_copy_select.sv
sim/dcs_vote_checker.sv
sim/dvfs_copy_select_tb.sv
